/* rtl/core/led_matrix_row_scanner_macros.svh */
`ifndef LED_MATRIX_ROW_SCANNER_MACROS_SVH
`define LED_MATRIX_ROW_SCANNER_MACROS_SVH

// same-cycle implication, checked outside reset
`define LMRS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define LMRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/lmrs_pkg.sv */
package lmrs_pkg;

	localparam int COLUMNS_DEF = 48;
	localparam int ROWS_DEF = 16;
	localparam int SHIFT_BITS = 48;
	localparam int CNT_W = 6;
	localparam int ADDR_W = 4;
	localparam int LIT_W = 16;
	localparam int PADDR_W = 2;
	localparam logic [LIT_W-1:0] ON_TIME_RESET = 16'd100;
	localparam int REG_ON_TIME = 0;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_CLEAR = 2'd1,
		OP_TICK  = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		PH_SHIFT = 2'd0,
		PH_LATCH = 2'd1,
		PH_LIT   = 2'd2
	} scan_phase_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [5:0] col;
		logic [3:0] line;
		logic pixel_on;
	} in_item_t;

	typedef struct packed {
		logic serial_data;
		logic shift_strobe;
		logic latch_pulse;
		logic blank;
		logic [3:0] row_select;
	} out_item_t;

	typedef struct packed {
		logic wr;
		logic clr;
		logic [3:0] line;
		logic [5:0] col;
		logic pix;
	} store_req_t;

endpackage

/* rtl/core/lmrs_store.sv */
module lmrs_store import lmrs_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS = ROWS_DEF,
	localparam int ROW_W = $clog2(ROWS),
	localparam int COL_W = $clog2(COLUMNS)
) (
	input  logic clk,
	input  logic arst_n,
	input  store_req_t req,
	input  logic [ROW_W-1:0] rd_row,
	input  logic [COL_W-1:0] rd_bit,
	output logic rd_data
);

	logic [COLUMNS-1:0] rows_q [ROWS];
	logic wr_hit;

	assign wr_hit = req.wr && ({1'b0, req.col} < 7'(COLUMNS)) && ({1'b0, req.line} < 5'(ROWS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= '{default: '0};
		end else if (req.clr) begin
			rows_q <= '{default: '0};
		end else if (wr_hit) begin
			rows_q[req.line[ROW_W-1:0]][req.col[COL_W-1:0]] <= req.pix;
		end
	end

	assign rd_data = rows_q[rd_row][rd_bit];

endmodule

/* rtl/core/lmrs_scan.sv */
module lmrs_scan import lmrs_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS = ROWS_DEF,
	localparam int ROW_W = $clog2(ROWS),
	localparam int COL_W = $clog2(COLUMNS),
	localparam int ROWS_W = $clog2(ROWS + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  in_item_t item,
	input  logic [LIT_W-1:0] on_time,
	input  logic rd_data,
	output logic [ROW_W-1:0] rd_row,
	output logic [COL_W-1:0] rd_bit,
	output out_item_t result
);

	`include "led_matrix_row_scanner_macros.svh"

	scan_phase_t phase_q, phase_n;
	logic [ROWS_W-1:0] scan_row_q, scan_row_n, row_wrap;
	logic [CNT_W-1:0] bit_count_q, bit_count_n, b;
	logic [LIT_W-1:0] lit_count_q, lit_count_n, lit_inc;
	logic [ADDR_W-1:0] held_addr_q, held_addr_n;
	logic is_tick, real_row;

	assign is_tick = item.opcode == OP_TICK;
	assign real_row = scan_row_q < ROWS_W'(ROWS);
	assign row_wrap = (scan_row_q >= ROWS_W'(ROWS)) ? '0 : scan_row_q + 1'b1;
	assign lit_inc = lit_count_q + 1'b1;
	// an unused phase code restarts the shift from bit zero
	assign b = (phase_q == PH_SHIFT) ? bit_count_q : '0;
	assign rd_row = scan_row_q[ROW_W-1:0];
	assign rd_bit = b[COL_W-1:0];

	always_comb begin
		phase_n = phase_q;
		scan_row_n = scan_row_q;
		bit_count_n = bit_count_q;
		lit_count_n = lit_count_q;
		held_addr_n = held_addr_q;
		if (is_tick) begin
			case (phase_q)
				PH_LATCH: begin
					lit_count_n = '0;
					if (on_time == '0) begin
						scan_row_n = row_wrap;
						phase_n = PH_SHIFT;
						bit_count_n = '0;
					end else begin
						phase_n = PH_LIT;
					end
				end
				PH_LIT: begin
					if (lit_inc >= on_time || lit_inc == '0) begin
						scan_row_n = row_wrap;
						phase_n = PH_SHIFT;
						bit_count_n = '0;
						lit_count_n = '0;
					end else begin
						lit_count_n = lit_inc;
					end
				end
				default: begin
					phase_n = PH_SHIFT;
					if (real_row && b == '0) begin
						held_addr_n = ADDR_W'(ROWS_W'(ROWS - 1) - scan_row_q);
					end
					if ({1'b0, b} + 7'd1 >= 7'(SHIFT_BITS)) begin
						phase_n = PH_LATCH;
						bit_count_n = '0;
					end else begin
						bit_count_n = b + 1'b1;
					end
				end
			endcase
		end
	end

	always_comb begin
		result = '0;
		result.row_select = held_addr_n;
		if (is_tick) begin
			case (phase_q)
				PH_LATCH: begin
					result.blank = 1'b1;
					result.latch_pulse = 1'b1;
				end
				PH_LIT: begin
					result.blank = 1'b0;
				end
				default: begin
					result.blank = 1'b1;
					result.shift_strobe = 1'b1;
					// active low; columns past the panel and the blank pass send off
					if (real_row && ({1'b0, b} < 7'(COLUMNS))) begin
						result.serial_data = ~rd_data;
					end else begin
						result.serial_data = 1'b1;
					end
				end
			endcase
		end else begin
			result.blank = phase_q != PH_LIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SHIFT;
			scan_row_q <= '0;
			bit_count_q <= '0;
			lit_count_q <= '0;
			held_addr_q <= '0;
		end else if (go) begin
			phase_q <= phase_n;
			scan_row_q <= scan_row_n;
			bit_count_q <= bit_count_n;
			lit_count_q <= lit_count_n;
			held_addr_q <= held_addr_n;
		end
	end

	`LMRS_ASSERT_NOW(a_latch_bit_zero, phase_q == PH_LATCH, bit_count_q == '0, "bit count not cleared at latch")
	`LMRS_ASSERT_NOW(a_lit_count_idle, phase_q != PH_LIT, lit_count_q == '0, "lit count left over outside lit phase")
	`LMRS_ASSERT_NEXT(a_row_range, 1'b1, scan_row_q <= ROWS_W'(ROWS), "scan row past blank pass")

endmodule

/* rtl/core/led_matrix_row_scanner.sv */
// channel   direction  handshake                payload
// item      in         item_valid / item_stall  item   (in_item_t)
// result    out        result_valid / result_stall  result (out_item_t)
// config    in         psel / penable / pready  paddr, pwdata, prdata (on_time)
//
// one request enters per cycle while item_stall is low; it passes the input
// register, then the result register, and every request gives one result
// arst_n clears the scan state and the frame store and sets on_time to 100
// a stalled result holds the result register; item_stall rises once the input
// register is full and cannot move on
module led_matrix_row_scanner import lmrs_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  in_item_t item,
	output logic result_valid,
	input  logic result_stall,
	output out_item_t result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int ROW_W = $clog2(ROWS);
	localparam int COL_W = $clog2(COLUMNS);

	logic valid_s1;
	in_item_t item_s1;
	logic out_valid_q;
	out_item_t out_q;
	logic [LIT_W-1:0] on_time_q;
	logic out_free, advance, accept, reg_hit;
	store_req_t store_req;
	logic [ROW_W-1:0] rd_row;
	logic [COL_W-1:0] rd_bit;
	logic rd_data;
	out_item_t scan_result;

	assign out_free = !out_valid_q || !result_stall;
	assign advance = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign accept = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (out_free) begin
				out_valid_q <= advance;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (advance) begin
			out_q <= scan_result;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

	// configuration
	assign reg_hit = paddr == PADDR_W'(4 * REG_ON_TIME);
	assign pready = 1'b1;
	assign prdata = reg_hit ? {16'd0, on_time_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_time_q <= ON_TIME_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			on_time_q <= pwdata[LIT_W-1:0];
		end
	end

	always_comb begin
		store_req.wr = advance && item_s1.opcode == OP_WRITE;
		store_req.clr = advance && item_s1.opcode == OP_CLEAR;
		store_req.line = item_s1.line;
		store_req.col = item_s1.col;
		store_req.pix = item_s1.pixel_on;
	end

	lmrs_store #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.req(store_req),
		.rd_row(rd_row),
		.rd_bit(rd_bit),
		.rd_data(rd_data)
	);

	lmrs_scan #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.go(advance),
		.item(item_s1),
		.on_time(on_time_q),
		.rd_data(rd_data),
		.rd_row(rd_row),
		.rd_bit(rd_bit),
		.result(scan_result)
	);

endmodule
